// File: design/page_slot_allocator_core_assert.svh
// Assertion macros for the page slot allocator.
// Define ASSERT_OFF to compile them out.
`ifndef PAGE_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define PAGE_SLOT_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// cons must hold in the same cycle as ante
`define PSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: design/psa_pkg.sv
package psa_pkg;

    // pool size; must stay a power of two (ring pointers wrap by truncation)
    localparam int PSA_PAGES = 16;
    localparam int PSA_IDX_W = $clog2(PSA_PAGES);
    localparam int PSA_CNT_W = $clog2(PSA_PAGES + 1);

    // field widths
    localparam int PSA_REQ_W    = 2;
    localparam int PSA_SLOT_W   = 4;
    localparam int PSA_STATUS_W = 2;
    localparam int PSA_IN_W     = 8;
    localparam int PSA_OUT_W    = 8;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_WRITING  = 2'd1,
        SLOT_READABLE = 2'd2,
        SLOT_READING  = 2'd3
    } t_slot_st;

    typedef enum logic [PSA_REQ_W-1:0] {
        REQ_ALLOC      = 2'd0,
        REQ_MAKE_READ  = 2'd1,
        REQ_START_READ = 2'd2,
        REQ_FREE       = 2'd3
    } t_req;

    typedef enum logic [PSA_STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NO_FREE   = 2'd1,
        STS_BAD_STATE = 2'd2
    } t_status;

    // decision for one request
    typedef struct packed {
        t_status  status;
        logic     pop;      // take head of free list
        logic     push;     // append slot to free list
        logic     st_we;    // write slot state
        t_slot_st st_new;
        logic     notify;
    } t_psa_ctl;

endpackage

// File: design/page_slot_allocator_core.sv
// Page slot allocator. Each item carries one request (allocate, make readable,
// start reading, free) and yields exactly one result item with status, slot and
// notify. Each item reads the slot state and free-list memories synchronously, then
// decides and writes back when the output register can take the result; the block
// takes a new item only after the previous one has written back, and the result
// waits in an output register so the next item can be accepted while it is pending.
// Both memories come out of reset ready to use (entry valid bits stand in for the
// initial contents), so there is no clearing pass. notify_enable is written through
// i_cfg_wr_en / i_cfg_wr_data, by the user only while idle; the block does not enforce it.
`include "page_slot_allocator_core_assert.svh"

module page_slot_allocator_core
    import psa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config: notify_enable
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PSA_IN_W-1:0]  i_s_tdata,   // [1:0] req_type, [5:2] slot
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [PSA_OUT_W-1:0] o_m_tdata    // [1:0] status, [5:2] slot_out, [6] notify
);

    typedef enum logic {S_IDLE, S_EXEC} t_fsm;

    t_fsm                  r_state;
    logic                  r_notify_en;
    logic [PSA_IDX_W-1:0]  r_head;
    logic [PSA_CNT_W-1:0]  r_count;

    // captured request
    t_req                  r_req;
    logic [PSA_SLOT_W-1:0] r_slot;

    // memories and entry valid bits
    t_slot_st              r_st_mem [PSA_PAGES];
    logic [PSA_SLOT_W-1:0] r_q_mem  [PSA_PAGES];
    logic [PSA_PAGES-1:0]  r_st_vld;
    logic [PSA_PAGES-1:0]  r_q_vld;

    // registered read data
    t_slot_st              r_st_rd;
    logic                  r_st_rd_vld;
    logic [PSA_SLOT_W-1:0] r_q_rd;
    logic                  r_q_rd_vld;

    // output register
    logic                  r_out_vld;
    logic [PSA_OUT_W-1:0]  r_out_data;

    logic                  s_fire;
    logic                  commit;
    logic [PSA_SLOT_W-1:0] in_slot;
    logic [PSA_IDX_W-1:0]  rd_st_addr;
    t_slot_st              cur_st;
    logic [PSA_SLOT_W-1:0] popped;
    logic                  in_range;
    logic [PSA_IDX_W-1:0]  st_wr_addr;
    logic [PSA_IDX_W-1:0]  q_tail;
    logic [PSA_SLOT_W-1:0] slot_out;
    t_psa_ctl              ctl;
    logic [PSA_OUT_W-1:0]  n_out_data;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign commit     = (r_state == S_EXEC) && (!r_out_vld || i_m_tready);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    assign in_slot    = i_s_tdata[PSA_REQ_W +: PSA_SLOT_W];
    assign rd_st_addr = in_slot[PSA_IDX_W-1:0];

    // unwritten entries read as reset contents
    assign cur_st   = r_st_rd_vld ? r_st_rd : SLOT_FREE;
    assign popped   = r_q_rd_vld ? r_q_rd : PSA_SLOT_W'(r_head);
    assign in_range = PSA_CNT_W'(r_slot) < PSA_CNT_W'(PSA_PAGES);

    psa_rule u_rule (
        .i_req       (r_req),
        .i_in_range  (in_range),
        .i_cur       (cur_st),
        .i_empty     (r_count == '0),
        .i_full      (r_count == PSA_CNT_W'(PSA_PAGES)),
        .i_notify_en (r_notify_en),
        .o_ctl       (ctl)
    );

    // write-back addresses; tail wraps by truncation
    assign st_wr_addr = ctl.pop ? popped[PSA_IDX_W-1:0] : r_slot[PSA_IDX_W-1:0];
    assign q_tail     = r_head + r_count[PSA_IDX_W-1:0];
    assign slot_out   = ctl.pop ? popped : r_slot;
    assign n_out_data = {{(PSA_OUT_W - PSA_STATUS_W - PSA_SLOT_W - 1){1'b0}},
                         ctl.notify, slot_out, ctl.status};

    // control, pointers and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_notify_en <= 1'b0;
            r_head      <= '0;
            r_count     <= PSA_CNT_W'(PSA_PAGES);
            r_st_vld    <= '0;
            r_q_vld     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_notify_en <= i_cfg_wr_data;
            end
            // result leaves; a commit in the same cycle refills the register
            if (r_out_vld && i_m_tready && !commit) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state    <= S_IDLE;
                        r_out_vld  <= 1'b1;
                        r_out_data <= n_out_data;
                        if (ctl.st_we) begin
                            r_st_vld[st_wr_addr] <= 1'b1;
                        end
                        if (ctl.push) begin
                            r_q_vld[q_tail] <= 1'b1;
                        end
                        if (ctl.pop) begin
                            r_head  <= r_head + PSA_IDX_W'(1);
                            r_count <= r_count - PSA_CNT_W'(1);
                        end else if (ctl.push) begin
                            r_count <= r_count + PSA_CNT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request capture and memory reads
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_req       <= t_req'(i_s_tdata[PSA_REQ_W-1:0]);
            r_slot      <= in_slot;
            r_st_rd     <= r_st_mem[rd_st_addr];
            r_st_rd_vld <= r_st_vld[rd_st_addr];
            r_q_rd      <= r_q_mem[r_head];
            r_q_rd_vld  <= r_q_vld[r_head];
        end
    end

    // memory write-back
    always_ff @(posedge i_clk) begin
        if (commit && ctl.st_we) begin
            r_st_mem[st_wr_addr] <= ctl.st_new;
        end
        if (commit && ctl.push) begin
            r_q_mem[q_tail] <= r_slot;
        end
    end

    // checks
    `PSA_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= PSA_CNT_W'(PSA_PAGES), "free count above pool size")
    `PSA_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, commit && r_count == '0, !ctl.pop, "pop from empty free list")
    `PSA_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, commit && ctl.pop, r_count == $past(r_count) - PSA_CNT_W'(1), "free count not decremented on allocate")
    `PSA_ASSERT_IMPL(a_notify_ok, i_clk, i_rst_n, commit && ctl.notify, ctl.status == STS_OK && r_req == REQ_MAKE_READ, "notify on failed or wrong request")

endmodule

// File: design/psa_rule.sv
// Slot state transition rules for one request.
module psa_rule
    import psa_pkg::*;
(
    input  t_req     i_req,
    input  logic     i_in_range,
    input  t_slot_st i_cur,
    input  logic     i_empty,
    input  logic     i_full,
    input  logic     i_notify_en,
    output t_psa_ctl o_ctl
);

    always_comb begin
        o_ctl        = '0;
        o_ctl.status = STS_BAD_STATE;
        o_ctl.st_new = SLOT_FREE;
        case (i_req)
            REQ_ALLOC: begin
                if (i_empty) begin
                    o_ctl.status = STS_NO_FREE;
                end else begin
                    o_ctl.status = STS_OK;
                    o_ctl.pop    = 1'b1;
                    o_ctl.st_we  = 1'b1;
                    o_ctl.st_new = SLOT_WRITING;
                end
            end
            REQ_MAKE_READ: begin
                if (i_in_range && (i_cur == SLOT_WRITING || i_cur == SLOT_READING)) begin
                    o_ctl.status = STS_OK;
                    o_ctl.st_we  = 1'b1;
                    o_ctl.st_new = SLOT_READABLE;
                    o_ctl.notify = (i_cur == SLOT_WRITING) && i_notify_en;
                end
            end
            REQ_START_READ: begin
                if (i_in_range && i_cur == SLOT_READABLE) begin
                    o_ctl.status = STS_OK;
                    o_ctl.st_we  = 1'b1;
                    o_ctl.st_new = SLOT_READING;
                end
            end
            REQ_FREE: begin
                if (i_in_range && i_cur == SLOT_READABLE) begin
                    o_ctl.status = STS_OK;
                    o_ctl.st_we  = 1'b1;
                    o_ctl.st_new = SLOT_FREE;
                    // free-list overflow guard
                    o_ctl.push   = !i_full;
                end
            end
            default: begin
                o_ctl.status = STS_BAD_STATE;
            end
        endcase
    end

endmodule
